>>> sv/mpsm_pkg.sv
// Shared constants of the multi-pattern string matcher: operation codes and field widths.
package mpsm_pkg;
  localparam int OP_W  = 2;
  localparam int SYM_W = 5;
  localparam int POS_W = 16;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BLD  = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;
endpackage

>>> sv/multi_pattern_string_matcher.sv
// Aho-Corasick matcher: trie, failure links and word-end marks in on-chip memories.
// Every accepted word ends in a result strobe: an add, an undefined op, an out-of-range scan
// letter, a scan that walks failure hops and output-chain nodes, and a build that walks every
// trie node, its non-root children and their failure hops; single memory read ports pace it.
// One word at a time: busy drops in the strobe cycle, where the next word may be accepted.
// After reset a clearing pass over all MAX_NODES*ALPHABET child-table entries holds busy high.
module multi_pattern_string_matcher #(
  parameter int MAX_NODES = 256,
  parameter int ALPHABET  = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mpsm_pkg::OP_W-1:0]   in_op,
  input  logic [mpsm_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic                        out_match,
  output logic [mpsm_pkg::POS_W-1:0]  out_position,
  output logic                        out_status,
  output logic                        out_end_of_text
);
  localparam int CT_DEPTH = MAX_NODES * ALPHABET;
  localparam int CAW = $clog2(CT_DEPTH);
  localparam int NW  = $clog2(MAX_NODES);
  localparam int UW  = $clog2(MAX_NODES + 1);
  localparam int AW  = $clog2(ALPHABET);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_SK   = 4'd3;
  localparam logic [3:0] S_SF   = 4'd4;
  localparam logic [3:0] S_SM   = 4'd5;
  localparam logic [3:0] S_BPOP = 4'd6;
  localparam logic [3:0] S_BU   = 4'd7;
  localparam logic [3:0] S_BV   = 4'd8;
  localparam logic [3:0] S_BF   = 4'd9;
  localparam logic [3:0] S_BK   = 4'd10;

  function automatic logic [CAW-1:0] caddr(logic [NW-1:0] n, logic [CAW-1:0] s);
    return CAW'(n * ALPHABET) + s;
  endfunction

  // Memories.
  logic [NW-1:0] ct_mem [CT_DEPTH];
  logic [NW-1:0] fl_mem [MAX_NODES];
  logic          wm_mem [MAX_NODES];
  logic [NW-1:0] q_mem  [MAX_NODES];

  logic [CAW-1:0] ct_ra, ct_wa;
  logic [NW-1:0]  ct_wd, ct_q;
  logic           ct_we;
  logic [NW-1:0]  fl_ra, fl_wa, fl_wd, fl_q;
  logic           fl_we;
  logic [NW-1:0]  wm_ra, wm_wa;
  logic           wm_wd, wm_we, wm_q;
  logic [NW-1:0]  q_ra, q_wa, q_wd, q_q;
  logic           q_we;

  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_wa] <= ct_wd;
    ct_q <= ct_mem[ct_ra];
  end
  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_q <= fl_mem[fl_ra];
  end
  always_ff @(posedge clk) begin
    if (wm_we) wm_mem[wm_wa] <= wm_wd;
    wm_q <= wm_mem[wm_ra];
  end
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_q <= q_mem[q_ra];
  end

  // Control and working registers.
  logic [3:0]     state_r, state_nxt;
  logic [CAW-1:0] clr_r, clr_nxt;
  logic [mpsm_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [mpsm_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic           last_r, last_nxt;
  logic [NW-1:0]  cursor_r, cursor_nxt;
  logic [UW-1:0]  used_r, used_nxt;
  logic           broken_r, broken_nxt;
  logic [NW-1:0]  scan_r, scan_nxt;
  logic [mpsm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [NW-1:0]  s_r, s_nxt;
  logic [UW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]  u_r, u_nxt, v_r, v_nxt, f_r, f_nxt;
  logic [AW-1:0]  c_r, c_nxt;
  logic           ov_r, ov_nxt, om_r, om_nxt, os_r, os_nxt, oe_r, oe_nxt;
  logic [mpsm_pkg::POS_W-1:0] op_pos_r, op_pos_nxt;

  logic           in_sym_ok, sym_ok, full, nokid, brk, set_en, adv, scan_done, scan_hit;
  logic [NW-1:0]  nxt_node, set_v, set_link;
  logic [CAW-1:0] in_sym_w, sym_w;

  assign in_sym_ok = ({3'b000, in_symbol} < 8'(ALPHABET)) || (ALPHABET > 255);
  assign sym_ok    = ({3'b000, sym_r} < 8'(ALPHABET)) || (ALPHABET > 255);
  assign in_sym_w  = CAW'(in_symbol);
  assign sym_w     = CAW'(sym_r);
  assign full      = (used_r == UW'(MAX_NODES));
  assign nokid     = (ct_q == '0);

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;  op_nxt = op_r;  sym_nxt = sym_r;
    last_nxt = last_r;  cursor_nxt = cursor_r;  used_nxt = used_r;
    broken_nxt = broken_r;  scan_nxt = scan_r;  pos_nxt = pos_r;  s_nxt = s_r;
    head_nxt = head_r;  tail_nxt = tail_r;  u_nxt = u_r;  v_nxt = v_r;  f_nxt = f_r;
    c_nxt = c_r;
    ov_nxt = 1'b0;  om_nxt = 1'b0;  os_nxt = 1'b0;  oe_nxt = 1'b0;  op_pos_nxt = '0;
    ct_ra = '0;  ct_we = 1'b0;  ct_wa = '0;  ct_wd = '0;
    fl_ra = '0;  fl_we = 1'b0;  fl_wa = '0;  fl_wd = '0;
    wm_ra = '0;  wm_we = 1'b0;  wm_wa = '0;  wm_wd = 1'b0;
    q_ra = '0;   q_we = 1'b0;   q_wa = '0;   q_wd = '0;
    brk = broken_r;  nxt_node = ct_q;
    set_en = 1'b0;  set_v = '0;  set_link = '0;  adv = 1'b0;
    scan_done = 1'b0;  scan_hit = 1'b0;

    case (state_r)
      // Clear the child, failure-link and word-end tables after reset.
      S_CLR: begin
        ct_we = 1'b1;  ct_wa = clr_r;
        if (clr_r < CAW'(MAX_NODES)) begin
          fl_we = 1'b1;  fl_wa = clr_r[NW-1:0];
          wm_we = 1'b1;  wm_wa = clr_r[NW-1:0];
        end
        clr_nxt = clr_r + CAW'(1);
        if (clr_r == CAW'(CT_DEPTH - 1)) state_nxt = S_IDLE;
      end
      // Accept a word and issue its first access, or answer an undefined op or bad scan letter.
      S_IDLE: begin
        if (start) begin
          op_nxt = in_op;  sym_nxt = in_symbol;  last_nxt = in_last;
          case (in_op)
            mpsm_pkg::OP_ADD: begin
              ct_ra = caddr(cursor_r, in_sym_w);
              state_nxt = S_ADD;
            end
            mpsm_pkg::OP_BLD: begin
              q_we = 1'b1;  q_wa = '0;  q_wd = '0;
              head_nxt = '0;  tail_nxt = UW'(1);
              state_nxt = S_BPOP;
            end
            mpsm_pkg::OP_SCAN: begin
              if (in_sym_ok) begin
                ct_ra = caddr(scan_r, in_sym_w);
                s_nxt = scan_r;
                state_nxt = S_SK;
              end else begin
                scan_nxt = '0;
                scan_done = 1'b1;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      // Insert one pattern letter.
      S_ADD: begin
        os_nxt = sym_ok && nokid && full;
        if (!broken_r) begin
          if (!sym_ok) begin
            brk = 1'b1;
          end else if (nokid) begin
            if (full) begin
              brk = 1'b1;
            end else begin
              nxt_node = used_r[NW-1:0];
              used_nxt = used_r + UW'(1);
              ct_we = 1'b1;  ct_wa = caddr(cursor_r, sym_w);  ct_wd = used_r[NW-1:0];
            end
          end
          if (!brk) cursor_nxt = nxt_node;
        end
        broken_nxt = brk;
        if (last_r) begin
          if (!brk && cursor_nxt != '0) begin
            wm_we = 1'b1;  wm_wa = cursor_nxt;  wm_wd = 1'b1;
          end
          broken_nxt = 1'b0;
          cursor_nxt = '0;
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      // Scan: child lookup, following failure links on a miss.
      S_SK: begin
        if (s_r != '0 && nokid) begin
          fl_ra = s_r;
          state_nxt = S_SF;
        end else begin
          scan_nxt = ct_q;
          if (nokid) begin
            scan_done = 1'b1;
          end else begin
            wm_ra = ct_q;  fl_ra = ct_q;
            state_nxt = S_SM;
          end
        end
      end
      S_SF: begin
        s_nxt = fl_q;
        ct_ra = caddr(fl_q, sym_w);
        state_nxt = S_SK;
      end
      // Scan: walk the output chain for a word end.
      S_SM: begin
        if (wm_q) begin
          scan_hit = 1'b1;  scan_done = 1'b1;
        end else if (fl_q == '0) begin
          scan_done = 1'b1;
        end else begin
          wm_ra = fl_q;  fl_ra = fl_q;
        end
      end
      // Build: take the next node off the queue.
      S_BPOP: begin
        q_ra = head_r[NW-1:0];
        state_nxt = S_BU;
      end
      S_BU: begin
        u_nxt = q_q;  c_nxt = '0;  head_nxt = head_r + UW'(1);
        ct_ra = caddr(q_q, '0);
        state_nxt = S_BV;
      end
      S_BV: begin
        v_nxt = ct_q;
        if (nokid) begin
          adv = 1'b1;
        end else if (u_r == '0) begin
          set_en = 1'b1;  set_v = ct_q;  set_link = '0;
        end else begin
          fl_ra = u_r;
          state_nxt = S_BF;
        end
      end
      S_BF: begin
        f_nxt = fl_q;
        ct_ra = caddr(fl_q, CAW'(c_r));
        state_nxt = S_BK;
      end
      S_BK: begin
        if (f_r != '0 && nokid) begin
          fl_ra = f_r;
          state_nxt = S_BF;
        end else begin
          set_en = 1'b1;  set_v = v_r;
          set_link = (!nokid && ct_q != v_r) ? ct_q : '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Build: store a failure link and queue the child while the queue has room.
    if (set_en) begin
      fl_we = 1'b1;  fl_wa = set_v;  fl_wd = set_link;
      if (tail_r < UW'(MAX_NODES)) begin
        q_we = 1'b1;  q_wa = tail_r[NW-1:0];  q_wd = set_v;
        tail_nxt = tail_r + UW'(1);
      end
      adv = 1'b1;
    end
    // Build: step to the next letter or the next queued node, or end the build. The queue
    // is read in the cycle after, in S_BPOP, so that a child queued in this cycle is already stored.
    if (adv) begin
      if (c_r == AW'(ALPHABET - 1)) begin
        if (head_r == tail_nxt) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_BPOP;
        end
      end else begin
        c_nxt = c_r + AW'(1);
        ct_ra = caddr(u_r, CAW'(c_r) + CAW'(1));
        state_nxt = S_BV;
      end
    end
    // Scan: emit the result word and advance the text position.
    if (scan_done) begin
      ov_nxt = 1'b1;  om_nxt = scan_hit;  op_pos_nxt = pos_r;
      oe_nxt = (state_r == S_IDLE) ? in_last : last_r;
      if (pos_r != mpsm_pkg::POS_MAX) pos_nxt = pos_r + 16'd1;
      if (oe_nxt) begin
        scan_nxt = '0;  pos_nxt = '0;
      end
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;  clr_r <= '0;  cursor_r <= '0;  used_r <= UW'(1);
      broken_r <= 1'b0;  scan_r <= '0;  pos_r <= '0;  ov_r <= 1'b0;
      head_r <= '0;  tail_r <= '0;
    end else begin
      state_r <= state_nxt;  clr_r <= clr_nxt;  cursor_r <= cursor_nxt;
      used_r <= used_nxt;  broken_r <= broken_nxt;  scan_r <= scan_nxt;
      pos_r <= pos_nxt;  ov_r <= ov_nxt;  head_r <= head_nxt;  tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  sym_r <= sym_nxt;  last_r <= last_nxt;  s_r <= s_nxt;
    u_r <= u_nxt;  v_r <= v_nxt;  f_r <= f_nxt;  c_r <= c_nxt;
    om_r <= om_nxt;  os_r <= os_nxt;  oe_r <= oe_nxt;  op_pos_r <= op_pos_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_match       = om_r;
  assign out_status      = os_r;
  assign out_end_of_text = oe_r;
  assign out_position    = op_pos_r;

  // An accepted word either keeps the block busy or answers at once.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word produced neither work nor result");
  // The node count stays between the root alone and the table size.
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= UW'(1)) && (used_r <= UW'(MAX_NODES)))
    else $error("node count out of range");
  // A table-full status only comes from an add, never with scan fields.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_status |-> (!out_match && !out_end_of_text && op_r == mpsm_pkg::OP_ADD))
    else $error("status set on a non-add result");
  // The build queue head never passes its tail.
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BV || state_r == S_BF || state_r == S_BK) |-> (head_r <= tail_r))
    else $error("build queue underflow");
endmodule

>>> dv/multi_pattern_string_matcher_tb.sv
// Self-checking testbench of the multi-pattern string matcher with a scoreboard class.
module multi_pattern_string_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W     = mpsm_pkg::OP_W;
  localparam int SYM_W    = mpsm_pkg::SYM_W;
  localparam int POS_W    = mpsm_pkg::POS_W;
  localparam int NODES    = 256;
  localparam int LETTERS  = 26;
  localparam int IDLE_MAX = 11;
  localparam int WATCHDOG = 200000;
  localparam int DRAIN    = 40;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] position;
    logic             status;
    logic             end_of_text;
  } result_t;

  // Scoreboard: keeps its own copy of the automaton and the expected results.
  class match_scoreboard;
    int      kid_of [NODES*LETTERS];
    int      fail_of [NODES];
    bit      word_end [NODES];
    int      used;
    int      cursor;
    int      state;
    int      text_pos;
    bit      broken;
    result_t pending[$];
    int      errors;

    function new();
      foreach (kid_of[i]) kid_of[i] = 0;
      foreach (fail_of[i]) fail_of[i] = 0;
      foreach (word_end[i]) word_end[i] = 0;
      used = 1;
      cursor = 0;
      state = 0;
      text_pos = 0;
      broken = 0;
      errors = 0;
    endfunction

    function int kid(int node, int sym);
      return kid_of[node*LETTERS + sym];
    endfunction

    // Pattern letter into the trie; returns the table-full flag.
    function bit add_letter(int sym, bit last);
      bit full;
      int nxt;
      full = 0;
      if (!broken) begin
        if (sym >= LETTERS) begin
          broken = 1;
        end else begin
          nxt = kid(cursor, sym);
          if (nxt == 0) begin
            if (used >= NODES) begin
              broken = 1;
              full = 1;
            end else begin
              nxt = used;
              used++;
              kid_of[cursor*LETTERS + sym] = nxt;
            end
          end
          if (!broken) cursor = nxt;
        end
      end else if (sym < LETTERS && kid(cursor, sym) == 0 && used >= NODES) begin
        full = 1;
      end
      if (last) begin
        if (!broken && cursor != 0) word_end[cursor] = 1;
        broken = 0;
        cursor = 0;
      end
      return full;
    endfunction

    // Breadth-first computation of every failure link.
    function void build_links();
      int bq[NODES];
      int head, tail, u, v, f, t, lnk;
      head = 0;
      tail = 0;
      fail_of[0] = 0;
      bq[tail++] = 0;
      while (head < tail) begin
        u = bq[head++];
        for (int c = 0; c < LETTERS; c++) begin
          v = kid(u, c);
          if (v == 0) continue;
          lnk = 0;
          if (u != 0) begin
            f = fail_of[u];
            while (f != 0 && kid(f, c) == 0) f = fail_of[f];
            t = kid(f, c);
            if (t != 0 && t != v) lnk = t;
          end
          fail_of[v] = lnk;
          if (tail < NODES) bq[tail++] = v;
        end
      end
    endfunction

    // One text letter: advance the state and look along its failure chain.
    function bit scan_letter(int sym);
      int s;
      s = state;
      if (sym >= LETTERS) begin
        s = 0;
      end else begin
        while (s != 0 && kid(s, sym) == 0) s = fail_of[s];
        s = kid(s, sym);
      end
      state = s;
      while (s != 0) begin
        if (word_end[s]) return 1;
        s = fail_of[s];
      end
      return 0;
    endfunction

    // Accepted word: update the copy of the state and queue its result.
    function void note_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic last);
      result_t r;
      r = '0;
      case (op)
        mpsm_pkg::OP_ADD: begin
          r.status = add_letter(int'(sym), last);
        end
        mpsm_pkg::OP_BLD: begin
          build_links();
        end
        mpsm_pkg::OP_SCAN: begin
          r.match = scan_letter(int'(sym));
          r.position = POS_W'(text_pos);
          r.end_of_text = last;
          if (text_pos < int'(mpsm_pkg::POS_MAX)) text_pos++;
          if (last) begin
            state = 0;
            text_pos = 0;
          end
        end
        default: begin
        end
      endcase
      pending = {pending, r};
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Result strobe: compare every field with the oldest expectation.
    task check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = pending.pop_front();
      if (got.match !== exp_r.match)
        report($sformatf("match %b, expected %b", got.match, exp_r.match));
      if (got.position !== exp_r.position)
        report($sformatf("position %0d, expected %0d", got.position, exp_r.position));
      if (got.status !== exp_r.status)
        report($sformatf("status %b, expected %b", got.status, exp_r.status));
      if (got.end_of_text !== exp_r.end_of_text)
        report($sformatf("end_of_text %b, expected %b", got.end_of_text,
                         exp_r.end_of_text));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  in_op;
  logic [SYM_W-1:0] in_symbol;
  logic             in_last;
  logic             out_valid;
  logic             out_match;
  logic [POS_W-1:0] out_position;
  logic             out_status;
  logic             out_end_of_text;

  match_scoreboard sb;
  bit              idling;
  int              quiet_cycles;
  int              words_sent;

  multi_pattern_string_matcher dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_symbol(in_symbol), .in_last(in_last),
    .out_valid(out_valid), .out_match(out_match), .out_position(out_position),
    .out_status(out_status), .out_end_of_text(out_end_of_text)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one word: random idle gap, wait for the block to be free, then hold start.
  task send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic last);
    int gap;
    gap = idling ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    while (gap > 0 || busy) begin
      start = 1'b0;
      if (gap > 0) gap--;
      @(negedge clk);
    end
    start = 1'b1;
    in_op = op;
    in_symbol = sym;
    in_last = last;
    @(posedge clk);
    sb.note_word(op, sym, last);
    words_sent++;
  endtask

  // Holds the sender off until every expected result has come back.
  task wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task add_pattern(string word);
    for (int i = 0; i < word.len(); i++)
      send_word(mpsm_pkg::OP_ADD, SYM_W'(word[i] - "a"), i == word.len() - 1);
  endtask

  task scan_text(string txt);
    for (int i = 0; i < txt.len(); i++)
      send_word(mpsm_pkg::OP_SCAN, SYM_W'(txt[i] - "a"), i == txt.len() - 1);
  endtask

  // Random pattern of len letters up to the given symbol bound, odd symbols now and then.
  task random_pattern(int len, int top);
    logic [SYM_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      s = ($urandom_range(0, 19) == 0) ? SYM_W'($urandom_range(0, 31))
                                       : SYM_W'($urandom_range(0, top));
      send_word(mpsm_pkg::OP_ADD, s, i == len - 1);
    end
  endtask

  task random_text(int len, int top);
    logic [SYM_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      s = ($urandom_range(0, 24) == 0) ? SYM_W'($urandom_range(LETTERS, 31))
                                       : SYM_W'($urandom_range(0, top));
      send_word(mpsm_pkg::OP_SCAN, s, i == len - 1);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid) begin
      got.match = out_match;
      got.position = out_position;
      got.status = out_status;
      got.end_of_text = out_end_of_text;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no accepted word and no result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("multi_pattern_string_matcher_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_op = mpsm_pkg::OP_ADD;
    in_symbol = '0;
    in_last = 1'b0;
    idling = 1'b1;
    words_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a classic pattern set, broken patterns, odd symbols and the unused op.
    add_pattern("he");
    add_pattern("she");
    add_pattern("his");
    add_pattern("hers");
    send_word(mpsm_pkg::OP_ADD, SYM_W'(27), 1'b0);
    send_word(mpsm_pkg::OP_ADD, SYM_W'(0), 1'b1);
    send_word(mpsm_pkg::OP_ADD, SYM_W'(31), 1'b1);
    send_word(OP_NONE, SYM_W'(31), 1'b1);
    send_word(mpsm_pkg::OP_BLD, '0, 1'b0);
    scan_text("ushers");
    send_word(mpsm_pkg::OP_SCAN, SYM_W'(30), 1'b0);
    send_word(OP_NONE, '0, 1'b0);
    wait_drained();
    scan_text("she");

    // Random mix of patterns, builds, texts and noise over a small alphabet.
    words_sent = 0;
    while (words_sent < 150) begin
      if ($urandom_range(0, 7) == 0) idling = ~idling;
      pick = $urandom_range(0, 99);
      if (pick < 35) random_pattern($urandom_range(1, 5), 3);
      else if (pick < 45) send_word(mpsm_pkg::OP_BLD, SYM_W'($urandom_range(0, 31)),
                                    1'($urandom));
      else if (pick < 95) random_text($urandom_range(1, 12), 4);
      else send_word(OP_NONE, SYM_W'($urandom_range(0, 31)), 1'($urandom));
    end

    // Fill the node table, then keep adding, building and scanning.
    idling = 1'b0;
    for (int i = 0; i < 34; i++) random_pattern(8, LETTERS - 1);
    idling = 1'b1;
    for (int i = 0; i < 6; i++) random_pattern($urandom_range(1, 6), LETTERS - 1);
    send_word(mpsm_pkg::OP_BLD, '0, 1'b0);
    for (int i = 0; i < 6; i++) random_text($urandom_range(4, 12), LETTERS - 1);
    for (int i = 0; i < 6; i++) random_text($urandom_range(4, 12), 3);

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("multi_pattern_string_matcher_tb passed");
    end else begin
      $display("multi_pattern_string_matcher_tb failed");
    end
    $finish;
  end
endmodule
